// ===== hdl/gradient_palette_interpolator_core_assert.svh =====
// Assertion macros shared by the gradient palette interpolator RTL.
`ifndef GRADIENT_PALETTE_INTERPOLATOR_CORE_ASSERT_SVH
`define GRADIENT_PALETTE_INTERPOLATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gpi_pkg.sv =====
// Shared constants and the divider lane type of the gradient palette interpolator.
package gpi_pkg;

    localparam int PALETTE_SIZE       = 256;
    localparam int IDX_W              = 8;
    localparam int COLOR_W            = 8;
    localparam int NUM_CH             = 3;
    localparam int PROD_W             = 2 * COLOR_W;
    localparam int RGB_W              = NUM_CH * COLOR_W;
    localparam int STOP_W             = 32;
    localparam int COUNT_W            = 3;
    localparam int MIN_STOPS          = 2;

    localparam int CFG_IDX_W          = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WORD_0 = 3'd1;

    localparam logic [COUNT_W-1:0] STOP_COUNT_RESET  = 3'd2;
    localparam logic [STOP_W-1:0]  STOP_WORD_1_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE      = 8'hFF;

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = COLOR_W / DIV_BITS_PER_STAGE;
    localparam int FRONT_STAGES       = 4;

    typedef struct packed {
        logic [NUM_CH-1:0][COLOR_W-1:0] rem;
        logic [NUM_CH-1:0][COLOR_W-1:0] low;
        logic [NUM_CH-1:0][COLOR_W-1:0] quo;
        logic [COLOR_W-1:0]             dvsr;
        logic                           clamped;
        logic [RGB_W-1:0]               rgb;
    } t_div_lane;

endpackage

// ===== hdl/gradient_palette_interpolator_core.sv =====
// Top level of the gradient palette interpolator: stop registers, pipeline and handshakes.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in       | in        | i_in_valid / o_in_stall   | i_color_index
//  out      | out       | o_out_valid / i_out_stall | o_argb_color, o_clamped
//
// One request enters per cycle while the input is not stalled; each result passes through every stage register.
// The depth is set by 4 front stages (segment search, stop fetch, multiply, sum) and
// a 4-stage restoring divider that resolves two quotient bits per stage.
// Reset is synchronous and active low; it empties the pipeline and restores the stops.
// A stall on the output holds each full stage with no empty stage after it; empty stages still fill, so the input
// side is stalled only when the whole pipeline is full.
`include "gradient_palette_interpolator_core_assert.svh"

module gradient_palette_interpolator_core import gpi_pkg::*; #(
    parameter int MAX_STOPS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STOP_W-1:0]     i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IDX_W-1:0]      i_color_index,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STOP_W-1:0]     o_argb_color,
    output logic                  o_clamped
);

    localparam int SEG_W    = $clog2(MAX_STOPS);
    localparam int N_STAGES = FRONT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [MAX_STOPS-2:0] seg_oh;
        logic [MAX_STOPS-1:0] end_oh;
        logic                 clamped;
    } t_stage_a;

    typedef struct packed {
        logic [COLOR_W-1:0]             a;
        logic [COLOR_W-1:0]             b;
        logic [COLOR_W-1:0]             span;
        logic [NUM_CH-1:0][COLOR_W-1:0] c_lo;
        logic [NUM_CH-1:0][COLOR_W-1:0] c_hi;
        logic                           clamped;
        logic [RGB_W-1:0]               rgb;
    } t_stage_b;

    typedef struct packed {
        logic [NUM_CH-1:0][PROD_W-1:0] prod_hi;
        logic [NUM_CH-1:0][PROD_W-1:0] prod_lo;
        logic [COLOR_W-1:0]            span;
        logic                          clamped;
        logic [RGB_W-1:0]              rgb;
    } t_stage_c;

    // Configuration registers.
    logic [COUNT_W-1:0] r_stop_count;
    logic [STOP_W-1:0]  r_stop_word [MAX_STOPS];

    // Pipeline control.
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] adv;

    t_stage_a  r_sa, n_sa;
    t_stage_b  r_sb, n_sb;
    t_stage_c  r_sc, n_sc;
    t_div_lane r_sd, n_sd;
    t_div_lane w_lane [DIV_STAGES+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= STOP_COUNT_RESET;
            for (int k = 0; k < MAX_STOPS; k++) begin
                r_stop_word[k] <= (k == 1) ? STOP_WORD_1_RESET : '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STOP_COUNT) begin
                r_stop_count <= i_cfg_data[COUNT_W-1:0];
            end
            for (int k = 0; k < MAX_STOPS; k++) begin
                if (i_cfg_index == CFG_STOP_WORD_0 + CFG_IDX_W'(k)) begin
                    r_stop_word[k] <= i_cfg_data;
                end
            end
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        adv[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_out_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld[0] = adv[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < N_STAGES; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall = !adv[0];

    // Stage A: compare the index against every stop and pick the segment.
    always_comb begin
        logic [IDX_W-1:0]     idx_sat;
        logic [COUNT_W-1:0]   n_eff;
        logic [SEG_W-1:0]     last;
        logic [MAX_STOPS-1:0] ge;
        logic [MAX_STOPS-1:0] last_oh;
        logic                 below;
        logic                 above;
        logic                 found;

        idx_sat = (int'(i_color_index) > PALETTE_SIZE - 1) ? IDX_W'(PALETTE_SIZE - 1)
                                                            : i_color_index;
        if (r_stop_count < COUNT_W'(MIN_STOPS)) begin
            n_eff = COUNT_W'(MIN_STOPS);
        end else if (int'(r_stop_count) > MAX_STOPS) begin
            n_eff = COUNT_W'(MAX_STOPS);
        end else begin
            n_eff = r_stop_count;
        end
        last = SEG_W'(n_eff - COUNT_W'(1));

        for (int k = 0; k < MAX_STOPS; k++) begin
            ge[k]      = idx_sat >= r_stop_word[k][STOP_W-1 -: COLOR_W];
            last_oh[k] = (SEG_W'(k) == last);
        end
        below = !ge[0];
        above = |(ge & last_oh);

        // The lowest segment whose stops enclose the index wins.
        found = 1'b0;
        for (int j = 0; j < MAX_STOPS - 1; j++) begin
            n_sa.seg_oh[j] = !found && (SEG_W'(j) < last) && ge[j] && !ge[j+1];
            found          = found || n_sa.seg_oh[j];
        end

        n_sa.idx     = idx_sat;
        n_sa.clamped = below || above;
        n_sa.end_oh  = below ? MAX_STOPS'(1) : last_oh;
    end

    // Stage B: fetch the two stops of the segment and form the distances.
    always_comb begin
        logic [STOP_W-1:0] w_lo;
        logic [STOP_W-1:0] w_hi;
        logic [STOP_W-1:0] w_end;

        w_lo  = '0;
        w_hi  = '0;
        w_end = '0;
        for (int j = 0; j < MAX_STOPS - 1; j++) begin
            w_lo = w_lo | (r_sa.seg_oh[j] ? r_stop_word[j]   : '0);
            w_hi = w_hi | (r_sa.seg_oh[j] ? r_stop_word[j+1] : '0);
        end
        for (int k = 0; k < MAX_STOPS; k++) begin
            w_end = w_end | (r_sa.end_oh[k] ? r_stop_word[k] : '0);
        end

        n_sb.a       = r_sa.idx - w_lo[STOP_W-1 -: COLOR_W];
        n_sb.b       = w_hi[STOP_W-1 -: COLOR_W] - r_sa.idx;
        n_sb.span    = w_hi[STOP_W-1 -: COLOR_W] - w_lo[STOP_W-1 -: COLOR_W];
        n_sb.c_lo    = w_lo[RGB_W-1:0];
        n_sb.c_hi    = w_hi[RGB_W-1:0];
        n_sb.clamped = r_sa.clamped;
        n_sb.rgb     = w_end[RGB_W-1:0];
    end

    // Stage C: weight each end color by the distance to the other end.
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sc.prod_hi[ch] = PROD_W'(r_sb.a) * PROD_W'(r_sb.c_hi[ch]);
            n_sc.prod_lo[ch] = PROD_W'(r_sb.b) * PROD_W'(r_sb.c_lo[ch]);
        end
        n_sc.span    = r_sb.span;
        n_sc.clamped = r_sb.clamped;
        n_sc.rgb     = r_sb.rgb;
    end

    // Stage D: sum the weights. The sum is below 256 times the spacing, so its
    // upper byte already fits as the first partial remainder.
    always_comb begin
        logic [PROD_W-1:0] num;
        num = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            num = r_sc.prod_hi[ch] + r_sc.prod_lo[ch];
            n_sd.rem[ch] = num[PROD_W-1:COLOR_W];
            n_sd.low[ch] = num[COLOR_W-1:0];
        end
        n_sd.quo     = '0;
        n_sd.dvsr    = r_sc.span;
        n_sd.clamped = r_sc.clamped;
        n_sd.rgb     = r_sc.rgb;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_sa <= n_sa;
        end
        if (adv[1]) begin
            r_sb <= n_sb;
        end
        if (adv[2]) begin
            r_sc <= n_sc;
        end
        if (adv[3]) begin
            r_sd <= n_sd;
        end
    end

    assign w_lane[0] = r_sd;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        gpi_div_step u_div_step (
            .i_clk  (i_clk),
            .i_en   (adv[FRONT_STAGES + s]),
            .i_lane (w_lane[s]),
            .o_lane (w_lane[s+1])
        );
    end

    assign o_out_valid  = r_vld[N_STAGES-1];
    assign o_clamped    = w_lane[DIV_STAGES].clamped;
    assign o_argb_color = {ALPHA_OPAQUE, w_lane[DIV_STAGES].clamped ? w_lane[DIV_STAGES].rgb
                                                                    : w_lane[DIV_STAGES].quo};

    `GPI_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0], "accepted request did not enter the pipeline")
    `GPI_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, (&r_vld) && i_out_stall, o_in_stall, "full pipeline took a new request")
    `GPI_ASSERT_NOW(a_span_nonzero, i_clk, i_rst_n, r_vld[1] && !r_sb.clamped, r_sb.span != '0, "interpolated request has zero stop spacing")
    `GPI_ASSERT_NOW(a_div_range, i_clk, i_rst_n, r_vld[3] && !r_sd.clamped, (r_sd.rem[0] < r_sd.dvsr) && (r_sd.rem[1] < r_sd.dvsr) && (r_sd.rem[2] < r_sd.dvsr), "quotient would not fit in a color byte")

endmodule

// ===== hdl/gpi_div_step.sv =====
// One registered stage of the restoring divider: two quotient bits for each color channel.
module gpi_div_step import gpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane n_lane;
    t_div_lane r_lane;

    // The partial remainder stays below the divisor, so each step shifts in one
    // dividend bit and subtracts the divisor at most once.
    always_comb begin
        logic [COLOR_W:0] trial;
        n_lane = i_lane;
        trial  = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int s = 0; s < DIV_BITS_PER_STAGE; s++) begin
                trial = {n_lane.rem[ch], n_lane.low[ch][COLOR_W-1]};
                n_lane.low[ch] = {n_lane.low[ch][COLOR_W-2:0], 1'b0};
                if (trial >= {1'b0, n_lane.dvsr}) begin
                    n_lane.rem[ch] = COLOR_W'(trial - {1'b0, n_lane.dvsr});
                    n_lane.quo[ch] = {n_lane.quo[ch][COLOR_W-2:0], 1'b1};
                end else begin
                    n_lane.rem[ch] = trial[COLOR_W-1:0];
                    n_lane.quo[ch] = {n_lane.quo[ch][COLOR_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== bench/tb_gradient_palette_interpolator_core.sv =====
// Self-checking testbench for the gradient palette interpolator core.
`timescale 1ns / 100ps

module tb_gradient_palette_interpolator_core;
    import gpi_pkg::*;

    localparam int MAX_STOPS = 7;
    localparam int LATENCY = 8;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 135;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    typedef struct packed {
        logic [STOP_W-1:0] argb;
        logic              clamped;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_STOP_COUNT;
    logic [STOP_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [IDX_W-1:0]     i_color_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STOP_W-1:0]    o_argb_color;
    logic                 o_clamped;

    // Local copy of the stop registers, updated as each write is taken.
    logic [COUNT_W-1:0]   stop_count_q = STOP_COUNT_RESET;
    logic [STOP_W-1:0]    stop_words [MAX_STOPS];
    logic [STOP_W-1:0]    next_words [MAX_STOPS];

    logic [IDX_W-1:0]     index_queue [$];
    t_pixel               expected_pixels [$];
    int                   requests_queued = 0;
    int                   pixels_checked = 0;
    int                   fail_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    gradient_palette_interpolator_core #(
        .MAX_STOPS(MAX_STOPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_color_index (i_color_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_argb_color  (o_argb_color),
        .o_clamped     (o_clamped)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_600_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_pixel predict_pixel(input logic [IDX_W-1:0] idx);
        int unsigned n;
        int unsigned last;
        int unsigned seg;
        int unsigned k;
        int unsigned ch;
        int unsigned p0;
        int unsigned p1;
        int unsigned num;
        bit found;
        logic [RGB_W-1:0] rgb;
        t_pixel px;
        n = stop_count_q;
        if (n < MIN_STOPS) n = MIN_STOPS;
        if (n > MAX_STOPS) n = MAX_STOPS;
        last = n - 1;
        px.clamped = 1'b1;
        if (idx < stop_words[0][31:24]) begin
            rgb = stop_words[0][RGB_W-1:0];
        end else if (idx >= stop_words[last][31:24]) begin
            rgb = stop_words[last][RGB_W-1:0];
        end else begin
            px.clamped = 1'b0;
            seg = 0;
            found = 1'b0;
            // With unsorted positions the lowest enclosing pair wins.
            for (k = 0; k < last; k++) begin
                if (!found && stop_words[k][31:24] <= idx && idx < stop_words[k+1][31:24]) begin
                    seg = k;
                    found = 1'b1;
                end
            end
            p0 = stop_words[seg][31:24];
            p1 = stop_words[seg+1][31:24];
            for (ch = 0; ch < NUM_CH; ch++) begin
                num = (idx - p0) * stop_words[seg+1][COLOR_W*ch +: COLOR_W]
                    + (p1 - idx) * stop_words[seg][COLOR_W*ch +: COLOR_W];
                rgb[COLOR_W*ch +: COLOR_W] = COLOR_W'(num / (p1 - p0));
            end
        end
        px.argb = {ALPHA_OPAQUE, rgb};
        return px;
    endfunction

    // Request driver: takes the next index from the queue unless idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_color_index <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_pixels.push_back(predict_pixel(i_color_index));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (index_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_color_index <= index_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR: unexpected result argb=%h clamped=%b",
                                 o_argb_color, o_clamped);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (o_argb_color !== want.argb || o_clamped !== want.clamped) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("ERROR: result %0d argb exp=%h got=%h clamped exp=%b got=%b",
                                     pixels_checked, want.argb, o_argb_color,
                                     want.clamped, o_clamped);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_STOP_COUNT) begin
            stop_count_q = data[COUNT_W-1:0];
        end else begin
            stop_words[idx - CFG_STOP_WORD_0] = data;
        end
    endtask

    task automatic program_palette(input logic [COUNT_W-1:0] cnt);
        write_reg(CFG_STOP_COUNT, {{(STOP_W-COUNT_W){1'b0}}, cnt});
        for (int k = 0; k < MAX_STOPS; k++) begin
            write_reg(CFG_STOP_WORD_0 + k[CFG_IDX_W-1:0], next_words[k]);
        end
    endtask

    task automatic queue_index(input logic [IDX_W-1:0] idx);
        index_queue.push_back(idx);
        requests_queued++;
    endtask

    // Every request yields exactly one result, so the block is idle once all are back.
    task automatic wait_drained();
        while (pixels_checked < requests_queued) @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idling mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 76 : (mode == IDLE_BOTH) ? 8 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 8 : 0;
    endtask

    task automatic randomize_palette(output logic [COUNT_W-1:0] cnt);
        int mode;
        int n_eff;
        int p;
        logic [31:0] r;
        mode = $urandom_range(9);
        cnt = COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2, 7));
        n_eff = (cnt < MIN_STOPS) ? MIN_STOPS : cnt;
        p = $urandom_range(16);
        for (int k = 0; k < MAX_STOPS; k++) begin
            r = $urandom();
            if (mode < 7) begin
                // Ascending positions spread over the palette, duplicates allowed.
                next_words[k] = {p[7:0], r[23:0]};
                p = p + $urandom_range(0, 2 * 240 / (n_eff - 1));
                if (p > 255) p = 255;
            end else if (mode == 7) begin
                next_words[k] = r;
            end else begin
                case ($urandom_range(2))
                    0: next_words[k] = '0;
                    1: next_words[k] = '1;
                    default: next_words[k] = r;
                endcase
            end
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] cnt;
        int v;
        int k;
        for (int j = 0; j < MAX_STOPS; j++) stop_words[j] = '0;
        stop_words[1] = STOP_WORD_1_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset palette: black at 0 to white at 255.
        set_idling(IDLE_NONE);
        foreach (next_words[j]) next_words[j] = '0;
        queue_index(8'h00);
        queue_index(8'h01);
        queue_index(8'h7F);
        queue_index(8'h80);
        queue_index(8'hAA);
        queue_index(8'h55);
        queue_index(8'hFE);
        queue_index(8'hFF);
        wait_drained();

        // Full set of ascending stops with extreme colors.
        next_words = '{32'h10_00FF00, 32'h30_FF00FF, 32'h50_000000, 32'h80_FFFFFF,
                       32'hA0_123456, 32'hC0_FEDCBA, 32'hF0_00FFFF};
        program_palette(3'd7);
        queue_index(8'h00);
        queue_index(8'h0F);
        queue_index(8'h10);
        queue_index(8'h11);
        queue_index(8'h2F);
        queue_index(8'h30);
        queue_index(8'h65);
        queue_index(8'h9F);
        queue_index(8'hC0);
        queue_index(8'hEF);
        queue_index(8'hF0);
        queue_index(8'hFF);
        wait_drained();

        // Stop counts below the minimum, with the first two positions descending.
        next_words = '{32'h80_FF0000, 32'h40_0000FF, 32'hC0_00FF00, 32'h20_FFFFFF,
                       32'h90_000000, 32'h10_ABCDEF, 32'hE0_FFFFFF};
        program_palette(3'd0);
        queue_index(8'h7F);
        queue_index(8'hFF);
        wait_drained();
        write_reg(CFG_STOP_COUNT, 32'd1);
        queue_index(8'h80);
        wait_drained();

        // Unsorted positions where two segments enclose the same index.
        next_words = '{32'h20_FF0000, 32'h30_00FF00, 32'h90_0000FF, 32'h50_FFFFFF,
                       32'h80_000000, 32'h10_808080, 32'hE0_FF00FF};
        program_palette(3'd7);
        queue_index(8'h60);
        queue_index(8'h25);
        queue_index(8'hDF);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            randomize_palette(cnt);
            program_palette(cnt);
            set_idling(t_idling'(ph % 4));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Hold off the sender once until every outstanding result is back.
                if (ph == 5 && i == ITEMS_PER_PHASE / 2) wait_drained();
                if ($urandom_range(99) < 40) begin
                    k = $urandom_range(MAX_STOPS - 1);
                    v = int'(stop_words[k][31:24]) + int'($urandom_range(2)) - 1;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end else begin
                    v = $urandom_range(255);
                end
                queue_index(v[IDX_W-1:0]);
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            fail_count++;
            $display("ERROR: %0d results never arrived", expected_pixels.size());
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gpi_pkg.sv
hdl/gpi_div_step.sv
hdl/gradient_palette_interpolator_core.sv
bench/tb_gradient_palette_interpolator_core.sv
